// ===== hw/rtl/fqd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fqd_pkg;

    // operation codes on the func field
    localparam logic [2:0] FUNC_PUSH  = 3'd0;
    localparam logic [2:0] FUNC_FRONT = 3'd1;
    localparam logic [2:0] FUNC_CLEAR = 3'd2;
    localparam logic [2:0] FUNC_POP   = 3'd3;
    localparam logic [2:0] FUNC_PRINT = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic       write;     // append the incoming value
        logic       clear;     // drop all entries
        logic       start;     // arm a result sequence
        logic       err;       // sequence is a single status word
        logic [1:0] err_code;
        logic       pop;       // remove the entry once reported
        logic       dump;      // walk every stored entry
        logic       emit;      // load the output register
    } ctl_t;

    // datapath -> controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic emit_last;
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fqd_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fqd_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fqd_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fqd_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fqd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fqd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire logic [2:0]    func,
    output logic               cmd_ready,
    input  wire fqd_pkg::sts_t sts,
    output fqd_pkg::ctl_t      ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (func)
                        fqd_pkg::FUNC_PUSH:
                        begin
                            if (sts.full)
                            begin
                                ctl.start    = 1'b1;
                                ctl.err      = 1'b1;
                                ctl.err_code = fqd_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctl.write = 1'b1;
                            end
                        end
                        fqd_pkg::FUNC_FRONT, fqd_pkg::FUNC_POP, fqd_pkg::FUNC_PRINT:
                        begin
                            ctl.start = 1'b1;
                            if (sts.empty)
                            begin
                                ctl.err      = 1'b1;
                                ctl.err_code = fqd_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                ctl.pop  = (func == fqd_pkg::FUNC_POP);
                                ctl.dump = (func == fqd_pkg::FUNC_PRINT);
                            end
                        end
                        fqd_pkg::FUNC_CLEAR:
                        begin
                            if (sts.empty)
                            begin
                                ctl.start    = 1'b1;
                                ctl.err      = 1'b1;
                                ctl.err_code = fqd_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                ctl.clear = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused codes: no effect
                        end
                    endcase
                    if (ctl.start)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                ctl.emit = sts.out_free;
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fqd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fqd_datapath #(
    parameter int DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fqd_pkg::ctl_t      ctl,
    output fqd_pkg::sts_t           sts,
    input  wire logic signed [31:0] value,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic [1:0]              rsp_status,
    output logic signed [31:0]      rsp_data,
    output logic                    rsp_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    logic signed [31:0] mem [DEPTH];

    logic [IW-1:0] head_reg;
    logic [IW-1:0] tail_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] walk_reg;
    logic [CW-1:0] remain_reg;
    logic          err_reg;
    logic [1:0]    code_reg;
    logic          pop_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_data_reg;
    logic               out_last_reg;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        wrap_inc = (idx == LAST_IDX) ? '0 : idx + IW'(1);
    endfunction

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == FULL_CNT);
    assign sts.out_free  = !out_valid_reg || rsp_ready;
    assign sts.emit_last = (remain_reg == ONE_CNT);

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_data   = out_data_reg;
    assign rsp_last   = out_last_reg;

    // slot memory: one write, one registered read into the output word
    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            mem[tail_reg] <= value;
        end
        if (ctl.emit)
        begin
            out_status_reg <= err_reg ? code_reg : fqd_pkg::STATUS_OK;
            out_data_reg   <= err_reg ? '0 : mem[walk_reg];
            out_last_reg   <= sts.emit_last;
        end
    end

    // sequence payload
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            walk_reg   <= head_reg;
            remain_reg <= (ctl.dump && !ctl.err) ? count_reg : ONE_CNT;
            err_reg    <= ctl.err;
            code_reg   <= ctl.err_code;
            pop_reg    <= ctl.pop && !ctl.err;
        end
        else if (ctl.emit)
        begin
            walk_reg   <= wrap_inc(walk_reg);
            remain_reg <= remain_reg - ONE_CNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            else if (ctl.write)
            begin
                tail_reg  <= wrap_inc(tail_reg);
                count_reg <= count_reg + ONE_CNT;
            end
            else if (ctl.emit && pop_reg)
            begin
                head_reg  <= wrap_inc(head_reg);
                count_reg <= count_reg - ONE_CNT;
            end

            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fifo_queue_with_dump_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// FIFO queue of signed 32-bit values held in a ring buffer of DEPTH slots.
// Each command word carries one operation: push appends value (no result
// unless the queue is full, which gives one FULL status word), front reports
// the oldest entry, pop reports and removes it, clear empties the queue (no
// result), print streams every entry oldest first with last set on the final
// word. Front, pop, clear and print on an empty queue give one EMPTY status
// word. Unused operation codes are swallowed. Print gives one entry per cycle
// from the slot memory's single read port while rsp.ready does not hold the
// response off. Slots hold nothing meaningful until pushed and need no
// clearing after reset; only the indices, fill count, response valid flag
// and sequencer state are reset.
module fifo_queue_with_dump_core #(
    parameter int DEPTH = 64    // 1 .. 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fqd_cmd_if.sink   cmd,
    fqd_rsp_if.source rsp
);

    fqd_pkg::ctl_t ctl;   // controller commands
    fqd_pkg::sts_t sts;   // datapath status

    // Sequencer: takes a command word only when idle, arms result sequences.
    fqd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .func      (cmd.func),
        .cmd_ready (cmd.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Slot memory, indices, fill count and the registered response word.
    fqd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .value      (cmd.value),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status),
        .rsp_data   (rsp.data),
        .rsp_last   (rsp.last)
    );

endmodule
`default_nettype wire

// ===== tb/sv/fifo_queue_with_dump_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the ring-buffer queue. A negedge driver feeds
// command words from a backlog, a posedge monitor compares every response
// word with the oldest prediction, and both sides idle at random.
module fifo_queue_with_dump_core_tb;

    localparam int QDEPTH = 64;

    // func codes the block must swallow without a response
    localparam logic [2:0] FUNC_RSVD_A = 3'd5;
    localparam logic [2:0] FUNC_RSVD_B = 3'd6;
    localparam logic [2:0] FUNC_RSVD_C = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    // Slowest legal run: ~330 words, each up to QDEPTH responses that may
    // each wait out the longest random stall, plus gaps; the limit is several times that.
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int unsigned TAIL_CYCLES = 200;      // quiet time to catch stray words
    localparam int unsigned HOLD_AT     = 60;       // command words taken before the long stall
    localparam int unsigned LONG_HOLD   = 400;      // response side held off this long

    typedef struct {
        logic [2:0]         func;
        logic signed [31:0] value;
        bit                 wait_idle;  // hold this word back until nothing is due
    } cmd_word_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    fqd_cmd_if cmd ();
    fqd_rsp_if rsp ();

    fifo_queue_with_dump_core #(
        .DEPTH (QDEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    // -------------------------------------------------------------------
    // Predicted queue contents: own ring, head, tail and fill count
    // -------------------------------------------------------------------
    logic signed [31:0] ring [QDEPTH];
    logic [5:0]         head_q;
    logic [5:0]         tail_q;
    int unsigned        fill_q;

    cmd_word_t   cmd_backlog [$];   // words still to be offered
    rsp_word_t   due_words [$];     // responses predicted but not yet seen

    int unsigned offer_cnt;         // command words put on the bus
    int unsigned taken_cnt;         // command words accepted by the block
    int unsigned err_cnt;
    int unsigned cycle_cnt;

    int unsigned cmd_gap;
    int unsigned cmd_calm;
    int unsigned rsp_stall;
    int unsigned rsp_calm;
    int unsigned hold_left;
    bit          hold_done;
    cmd_word_t   nxt_cmd;

    function automatic logic [5:0] step_idx(input logic [5:0] i);
        return (i == QDEPTH - 1) ? 6'd0 : i + 6'd1;
    endfunction

    task automatic due_word(input logic [1:0] st, input logic signed [31:0] d, input logic l);
        rsp_word_t w;
        w.status = st;
        w.data   = d;
        w.last   = l;
        due_words.push_back(w);
    endtask

    // Applies one accepted command word to the predicted queue and lists
    // the response words it should cause.
    task automatic queue_op(input logic [2:0] op, input logic signed [31:0] v);
        logic [5:0]  idx;
        int unsigned k;
        case (op)
            fqd_pkg::FUNC_PUSH:
                if (fill_q == QDEPTH)
                    due_word(fqd_pkg::STATUS_FULL, '0, 1'b1);
                else
                begin
                    ring[tail_q] = v;
                    tail_q = step_idx(tail_q);
                    fill_q++;
                end
            fqd_pkg::FUNC_FRONT:
                if (fill_q == 0)
                    due_word(fqd_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                    due_word(fqd_pkg::STATUS_OK, ring[head_q], 1'b1);
            fqd_pkg::FUNC_CLEAR:
                if (fill_q == 0)
                    due_word(fqd_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    head_q = '0;
                    tail_q = '0;
                    fill_q = 0;
                end
            fqd_pkg::FUNC_POP:
                if (fill_q == 0)
                    due_word(fqd_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    due_word(fqd_pkg::STATUS_OK, ring[head_q], 1'b1);
                    head_q = step_idx(head_q);
                    fill_q--;
                end
            fqd_pkg::FUNC_PRINT:
                if (fill_q == 0)
                    due_word(fqd_pkg::STATUS_EMPTY, '0, 1'b1);
                else
                begin
                    idx = head_q;
                    for (k = 0; k < fill_q; k++)
                    begin
                        due_word(fqd_pkg::STATUS_OK, ring[idx], k + 1 == fill_q);
                        idx = step_idx(idx);
                    end
                end
            default: ;  // reserved codes: no state change, no response
        endcase
    endtask

    // Mostly short gaps, a few long ones, and now and then a calm stretch
    // with no gaps at all.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic add_cmd(input logic [2:0] f, input logic signed [31:0] v,
                           input bit wait_idle = 1'b0);
        cmd_word_t c;
        c.func      = f;
        c.value     = v;
        c.wait_idle = wait_idle;
        cmd_backlog.push_back(c);
    endtask

    // One random operation; the mix leans towards pushes so the queue
    // wanders through its whole range and the indices wrap.
    task automatic add_random_cmd(input bit wait_idle = 1'b0);
        int unsigned        r;
        logic [2:0]         f;
        logic signed [31:0] v;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 42)
            f = fqd_pkg::FUNC_PUSH;
        else if (r < 62)
            f = fqd_pkg::FUNC_POP;
        else if (r < 72)
            f = fqd_pkg::FUNC_FRONT;
        else if (r < 79)
            f = fqd_pkg::FUNC_PRINT;
        else if (r < 84)
            f = fqd_pkg::FUNC_CLEAR;
        else if (r < 88)
            f = 3'($urandom_range(FUNC_RSVD_A, FUNC_RSVD_C));
        else
            f = fqd_pkg::FUNC_PUSH;
        add_cmd(f, v, wait_idle);
    endtask

    // Pushes past full so the surplus is dropped, then dumps, then drains a part.
    task automatic add_fill_burst();
        int unsigned k;
        for (k = 0; k < QDEPTH + 2; k++)
            add_cmd(fqd_pkg::FUNC_PUSH, $urandom);
        add_cmd(fqd_pkg::FUNC_PRINT, $urandom);
        for (k = 0; k < 6; k++)
            add_cmd(fqd_pkg::FUNC_POP, $urandom);
    endtask

    // -------------------------------------------------------------------
    // Clock
    // -------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -------------------------------------------------------------------
    // Command driver: changes the bus at the falling edge only. A word
    // counts as taken once taken_cnt has caught up with offer_cnt.
    // -------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd.valid || taken_cnt == offer_cnt)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_gap--;
                    cmd.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].wait_idle && due_words.size() != 0))
                begin
                    nxt_cmd = cmd_backlog.pop_front();
                    cmd.func  <= nxt_cmd.func;
                    cmd.value <= nxt_cmd.value;
                    cmd.valid <= 1'b1;
                    offer_cnt++;
                    cmd_gap = pick_gap(cmd_calm);
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------------
    // Response ready: random stalls, plus one long hold-off once enough
    // command words have gone in, so the block backs up and stalls cmd.
    // -------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (!hold_done && taken_cnt >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp.ready <= 1'b0;
            end
            else if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                rsp_stall = pick_gap(rsp_calm);
            end
        end
    end

    // -------------------------------------------------------------------
    // Monitor: sampled at the rising edge. Responses are checked before
    // the command taken at the same edge is predicted; a response can
    // never stem from a word accepted at the same edge.
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("unexpected response word: status %0d data %0d last %0d",
                           rsp.status, rsp.data, rsp.last);
                    err_cnt++;
                end
                else
                begin
                    if (rsp.status !== due_words[0].status)
                    begin
                        $error("status: expected %0d, got %0d", due_words[0].status, rsp.status);
                        err_cnt++;
                    end
                    if (rsp.data !== due_words[0].data)
                    begin
                        $error("data: expected %0d, got %0d", due_words[0].data, rsp.data);
                        err_cnt++;
                    end
                    if (rsp.last !== due_words[0].last)
                    begin
                        $error("last: expected %0d, got %0d", due_words[0].last, rsp.last);
                        err_cnt++;
                    end
                    void'(due_words.pop_front());
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                queue_op(cmd.func, cmd.value);
                taken_cnt++;
            end
        end
    end

    // Watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // -------------------------------------------------------------------
    // Stimulus, reset and end of run
    // -------------------------------------------------------------------
    initial
    begin
        int unsigned seg;
        int unsigned k;

        rst_n     = 1'b0;
        cmd.valid = 1'b0;
        cmd.func  = fqd_pkg::FUNC_PUSH;
        cmd.value = '0;
        rsp.ready = 1'b0;
        head_q    = '0;
        tail_q    = '0;
        fill_q    = 0;
        offer_cnt = 0;
        taken_cnt = 0;
        err_cnt   = 0;
        cycle_cnt = 0;
        cmd_gap   = 0;
        cmd_calm  = 0;
        rsp_stall = 0;
        rsp_calm  = 0;
        hold_left = 0;
        hold_done = 1'b0;

        // Directed: every operation on an empty queue, extreme values,
        // reserved codes, dump of a short queue, clear of a non-empty one.
        add_cmd(fqd_pkg::FUNC_FRONT, '0);
        add_cmd(fqd_pkg::FUNC_POP,   '0);
        add_cmd(fqd_pkg::FUNC_CLEAR, '0);
        add_cmd(fqd_pkg::FUNC_PRINT, '0);
        add_cmd(fqd_pkg::FUNC_PUSH,  VAL_MIN);
        add_cmd(fqd_pkg::FUNC_PUSH,  VAL_MAX);
        add_cmd(fqd_pkg::FUNC_PUSH,  '0);
        add_cmd(fqd_pkg::FUNC_PUSH,  -32'sd1);
        add_cmd(FUNC_RSVD_A, -32'sd1);
        add_cmd(FUNC_RSVD_B, VAL_MIN);
        add_cmd(FUNC_RSVD_C, VAL_MAX);
        add_cmd(fqd_pkg::FUNC_FRONT, VAL_MAX);
        add_cmd(fqd_pkg::FUNC_PRINT, VAL_MIN);
        add_cmd(fqd_pkg::FUNC_POP,   '0);
        add_cmd(fqd_pkg::FUNC_POP,   '0);
        add_cmd(fqd_pkg::FUNC_PRINT, '0);
        add_cmd(fqd_pkg::FUNC_CLEAR, '0);
        add_cmd(fqd_pkg::FUNC_FRONT, '0);
        add_cmd(fqd_pkg::FUNC_PRINT, '0);

        // Random mix with two fill-to-overflow bursts; one word waits for
        // every prior response before it goes out.
        for (seg = 0; seg < 5; seg++)
        begin
            for (k = 0; k < 34; k++)
                add_random_cmd(seg == 2 && k == 0);
            if (seg == 1 || seg == 3)
                add_fill_burst();
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || taken_cnt != offer_cnt)
            @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        // catch any stray words after the last predicted one
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
